@@ rtl/signed_int_to_decimal_ascii_assert.svh @@
// Assertion macros shared by the signed integer to decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define SITDA_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define SITDA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sitda_pkg.sv @@
// Package with constants, command and status types for the decimal text converter.
package sitda_pkg;

  localparam logic [7:0] ASCII_ZERO  = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;
  localparam logic [3:0] BCD_ADJ_MIN = 4'd5;
  localparam logic [3:0] BCD_ADJ     = 4'd3;

  typedef struct packed {
    logic load;
    logic step;
    logic put_sign;
    logic put_digit;
  } cmd_t;

  typedef struct packed {
    logic neg;
    logic conv_done;
    logic last_digit;
    logic out_free;
  } status_t;

  // Number of decimal digits needed for the largest magnitude, 2**(bits-1).
  function automatic int unsigned num_digits(input int unsigned bits);
    logic [63:0]  lim;
    logic [63:0]  pw;
    int unsigned  n;
    lim = 64'd1 << (bits - 1);
    pw  = 64'd10;
    n   = 1;
    for (int k = 1; k < 20; k++) begin
      if (pw <= lim) begin
        n = k + 1;
      end
      pw = pw * 64'd10;
    end
    return n;
  endfunction

endpackage

@@ rtl/sitda_value_if.sv @@
// Handshake channel that carries one signed integer per transaction.
interface sitda_value_if #(
  parameter int unsigned VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic signed [VALUE_BITS-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink (input valid, input value, output ready);
endinterface

@@ rtl/sitda_char_if.sv @@
// Handshake channel that carries one ASCII character and its end marker per transaction.
interface sitda_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

@@ rtl/sitda_ctrl.sv @@
// Controller state machine that sequences conversion and character output.
module sitda_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sitda_pkg::status_t status_i,
  output sitda_pkg::cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_CONV  = 4'b0010,
    ST_SIGN  = 4'b0100,
    ST_DIGIT = 4'b1000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CONV;
        end
      end
      ST_CONV: begin
        cmd_o.step = 1'b1;
        if (status_i.conv_done) begin
          state_d = status_i.neg ? ST_SIGN : ST_DIGIT;
        end
      end
      ST_SIGN: begin
        if (status_i.out_free) begin
          cmd_o.put_sign = 1'b1;
          state_d        = ST_DIGIT;
        end
      end
      ST_DIGIT: begin
        if (status_i.out_free) begin
          cmd_o.put_digit = 1'b1;
          if (status_i.last_digit) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/sitda_dpath.sv @@
// Datapath with the shift-and-add-3 binary to BCD converter and the output register.
module sitda_dpath #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic signed [VALUE_BITS-1:0] value_i,
  input  sitda_pkg::cmd_t              cmd_i,
  output sitda_pkg::status_t           status_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [7:0]                   out_char_o,
  output logic                         out_last_o
);

  localparam int unsigned ND    = sitda_pkg::num_digits(VALUE_BITS);
  localparam int unsigned DIG_W = $clog2(ND);
  localparam int unsigned CNT_W = $clog2(VALUE_BITS + 1);
  localparam logic [DIG_W-1:0] TOP_MAX = DIG_W'(ND - 1);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  logic [VALUE_BITS-1:0] mag_q, mag_d;
  logic [3:0]            bcd_q [ND];
  logic [3:0]            bcd_d [ND];
  logic [3:0]            adj [ND];
  logic [3:0]            shf [ND];
  logic                  neg_q, neg_d;
  logic [DIG_W-1:0]      top_q, top_d;
  logic [DIG_W-1:0]      nxt_idx;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  out_valid_q, out_valid_d;
  logic [7:0]            out_char_q, out_char_d;
  logic                  out_last_q, out_last_d;
  logic                  put;

  assign put     = cmd_i.put_sign | cmd_i.put_digit;
  assign nxt_idx = top_q + DIG_W'(1);

  always_comb begin
    for (int i = 0; i < ND; i++) begin
      adj[i] = (bcd_q[i] >= sitda_pkg::BCD_ADJ_MIN) ? bcd_q[i] + sitda_pkg::BCD_ADJ
                                                    : bcd_q[i];
    end
    shf[0] = {adj[0][2:0], mag_q[VALUE_BITS-1]};
    for (int i = 1; i < ND; i++) begin
      shf[i] = {adj[i][2:0], adj[i-1][3]};
    end
  end

  always_comb begin
    mag_d = mag_q;
    bcd_d = bcd_q;
    neg_d = neg_q;
    top_d = top_q;
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      neg_d = value_i[VALUE_BITS-1];
      mag_d = value_i[VALUE_BITS-1] ? VALUE_BITS'(-value_i) : VALUE_BITS'(value_i);
      for (int i = 0; i < ND; i++) begin
        bcd_d[i] = 4'd0;
      end
      top_d = '0;
      cnt_d = CNT_W'(VALUE_BITS);
    end else if (cmd_i.step) begin
      mag_d = {mag_q[VALUE_BITS-2:0], 1'b0};
      bcd_d = shf;
      cnt_d = cnt_q - CNT_ONE;
      // The value at most doubles, so the leading digit moves up by one at most.
      if ((top_q != TOP_MAX) && (shf[nxt_idx] != 4'd0)) begin
        top_d = nxt_idx;
      end
    end else if (cmd_i.put_digit && (top_q != '0)) begin
      top_d = top_q - DIG_W'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_char_d  = out_char_q;
    out_last_d  = out_last_q;
    if (put) begin
      out_valid_d = 1'b1;
      out_char_d  = cmd_i.put_sign ? sitda_pkg::ASCII_MINUS
                                   : sitda_pkg::ASCII_ZERO + 8'(bcd_q[top_q]);
      out_last_d  = cmd_i.put_digit && (top_q == '0);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      top_q       <= '0;
      cnt_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      top_q       <= top_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mag_q      <= mag_d;
    bcd_q      <= bcd_d;
    neg_q      <= neg_d;
    out_char_q <= out_char_d;
    out_last_q <= out_last_d;
  end

  assign status_o.neg        = neg_q;
  assign status_o.conv_done  = (cnt_q == CNT_ONE);
  assign status_o.last_digit = (top_q == '0);
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

endmodule

@@ rtl/signed_int_to_decimal_ascii.sv @@
// Top level of the signed integer to decimal ASCII text converter.
// The value_i channel takes one two's-complement integer per transaction.
// The char_o channel gives its decimal text, one character per transaction,
// most significant digit first, with '-' ahead of negative values and no
// leading zeros; last is high on the final character of each number.
// After a value is accepted, it runs through a shift-and-add-3 BCD converter
// that takes one magnitude bit per cycle. When the conversion is done, the
// controller moves to the sign or digit state, which puts the first character
// into the output register; then one character leaves per cycle while the
// receiver keeps ready high.
// The next value is accepted while the final character still waits in the
// output register, so a stalled receiver holds back only the first character
// of the value that follows, not its conversion.
// A stalled receiver freezes the pending character, and the block waits.
// Reset clears the controller and empties the output register.
module signed_int_to_decimal_ascii #(
  parameter int unsigned VALUE_BITS = 32
) (
  input logic          clk_i,
  input logic          rst_ni,
  sitda_value_if.sink  value_i,
  sitda_char_if.source char_o
);

  `include "signed_int_to_decimal_ascii_assert.svh"

  sitda_pkg::cmd_t    cmd;
  sitda_pkg::status_t status;
  logic               accept;
  logic               put_any;

  sitda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (value_i.valid),
    .in_ready_o (value_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  sitda_dpath #(
    .VALUE_BITS (VALUE_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .value_i     (value_i.value),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (char_o.ready),
    .out_valid_o (char_o.valid),
    .out_char_o  (char_o.character),
    .out_last_o  (char_o.last)
  );

  assign accept  = value_i.valid && value_i.ready;
  assign put_any = cmd.put_sign || cmd.put_digit;

  `SITDA_ASSERT_SAME(a_put_needs_room, put_any, status.out_free, "character put without room")
  `SITDA_ASSERT_SAME(a_one_command, 1'b1, $onehot0(cmd), "more than one datapath command")
  `SITDA_ASSERT_NEXT(a_accept_starts_conv, accept, cmd.step && !put_any, "no conversion step")

endmodule
